>>> rtl/ddo_pkg.sv
package ddo_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 16;
   localparam int unsigned ATAN_DEPTH       = 24;
   localparam int unsigned ATAN_IDX_W       = $clog2(ATAN_DEPTH);

   // 0.60725 in Q2.30, and round(2^32 / two pi)
   localparam logic signed [32:0] CORDIC_GAIN    = 33'sd652032874;
   localparam logic [29:0]        INV_TWO_PI_Q32 = 30'd683565276;

   localparam logic [23:0] RAD_PER_TICK_RST   = 24'd68898;
   localparam logic [15:0] WHEEL_RADIUS_RST   = 16'd8520;
   localparam logic [23:0] INV_WHEEL_BASE_RST = 24'd140335;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_RAD_PER_TICK   = 2'd0,
      CSR_WHEEL_RADIUS   = 2'd1,
      CSR_INV_WHEEL_BASE = 2'd2
   } ddo_csr_type;

   typedef struct packed {
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
   } ddo_req_type;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic [15:0]        heading_angle;
      logic signed [15:0] linear_speed;
      logic signed [15:0] turn_rate;
      logic signed [31:0] left_wheel_angle;
      logic signed [31:0] right_wheel_angle;
   } ddo_rsp_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cosine;
      logic signed [31:0] sine;
   } ddo_rot_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DL,
      ST_DR,
      ST_RATE,
      ST_DS,
      ST_ARC,
      ST_ARC_WB,
      ST_TURN,
      ST_TURN_WB,
      ST_KLO,
      ST_KHI,
      ST_KHI_WB,
      ST_ROT_INIT,
      ST_ROT,
      ST_XLO,
      ST_XHI,
      ST_YLO,
      ST_YHI,
      ST_YHI_WB,
      ST_ACC,
      ST_OUT
   } ddo_state_type;

   typedef enum logic [1:0] {
      ROT_IDLE,
      ROT_RUN,
      ROT_FIX
   } ddo_rot_state_type;

   // atan(2^-i) as a 32 bit binary angle
   function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051D;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2E;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2F9;
         5'd15:   r = 32'h0000517C;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A2F;
         5'd19:   r = 32'h00000517;
         5'd20:   r = 32'h0000028B;
         5'd21:   r = 32'h00000145;
         5'd22:   r = 32'h000000A2;
         5'd23:   r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
      logic signed [15:0] r;
      if (v > 66'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -66'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/ddo_cordic.sv
module ddo_cordic #(
   parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          angle,
   output ddo_pkg::ddo_rot_type rot
);
   import ddo_pkg::*;

   localparam int unsigned RotSteps =
      (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
   localparam logic [ATAN_IDX_W-1:0] LastIdx = ATAN_IDX_W'(RotSteps - 1);

   ddo_rot_state_type state_ff, state_in;

   logic [ATAN_IDX_W-1:0] idx_ff, idx_in;
   logic signed [32:0]    x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                  flip_ff, flip_in;
   logic signed [31:0]    cos_ff, cos_in, sin_ff, sin_in;

   logic               load, run, fix;
   logic signed [32:0] z_raw, z_fold, xs, ys, at;
   logic               fold;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ROT_IDLE: if (start) state_in = ROT_RUN;
         ROT_RUN:  if (idx_ff == LastIdx) state_in = ROT_FIX;
         ROT_FIX:  state_in = ROT_IDLE;
         default:  state_in = ROT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      load = 1'b0;
      run  = 1'b0;
      fix  = 1'b0;
      unique case (state_ff)
         ROT_IDLE: load = start;
         ROT_RUN:  run  = 1'b1;
         ROT_FIX:  fix  = 1'b1;
         default:  load = 1'b0;
      endcase
   end

   // fold the angle into the right half plane, negate the result at the end
   always_comb begin
      z_raw = {angle[31], angle};
      fold  = 1'b0;
      z_fold = z_raw;
      if (z_raw > 33'sd1073741824) begin
         z_fold = z_raw - 33'sd2147483648;
         fold   = 1'b1;
      end else if (z_raw < -33'sd1073741824) begin
         z_fold = z_raw + 33'sd2147483648;
         fold   = 1'b1;
      end
   end

   assign xs = x_ff >>> idx_ff;
   assign ys = y_ff >>> idx_ff;
   assign at = {1'b0, atan_turn(idx_ff)};

   always_comb begin
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (load) begin
         idx_in  = '0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = z_fold;
         flip_in = fold;
      end
      if (run) begin
         idx_in = idx_ff + 1'b1;
         if (!z_ff[32]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
      end
      if (fix) begin
         cos_in = flip_ff ? -x_ff[31:0] : x_ff[31:0];
         sin_in = flip_ff ? -y_ff[31:0] : y_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ROT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   // cosine and sine registers are loaded at the edge that ends the done cycle
   assign rot.done   = fix;
   assign rot.cosine = cos_ff;
   assign rot.sine   = sin_ff;

endmodule

>>> rtl/diff_drive_odometry_top.sv
// rsp_valid rises when ST_OUT, once the output register is free, loads the result.
// req_ready is high only between items, in ST_IDLE, so one transfer is in flight at a time.
// A sample's sequence uses one shared 33x33 multiplier, run through 12 products, and the
// min(CORDIC_STEPS, 24) iterations of the CORDIC rotator.
// Reset (synchronous): pose, heading, wheel angles and last counts cleared,
// registers loaded with their defaults, no result pending.
module diff_drive_odometry_top #(
   parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ddo_pkg::ddo_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ddo_pkg::ddo_rsp_type              rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ddo_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ddo_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import ddo_pkg::*;

   ddo_state_type state_ff, state_in;

   // configuration
   logic [23:0] rpt_ff, rpt_in, ibase_ff, ibase_in;
   logic [15:0] rad_ff, rad_in;
   ddo_csr_type csr_idx;
   logic        csr_wr;

   // state kept across samples
   logic [31:0]        last_l_ff, last_l_in, last_r_ff, last_r_in;
   logic signed [31:0] acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic signed [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [15:0]        hd_ff, hd_in;

   // per sample working registers
   logic signed [31:0] tl_ff, tl_in, tr_ff, tr_in;
   logic signed [15:0] vl_ff, vl_in, vr_ff, vr_in, lin_ff, lin_in, rate_ff, rate_in;
   logic signed [31:0] dl_ff, dl_in, dr_ff, dr_in, arc_ff, arc_in;
   logic signed [32:0] ds_ff, ds_in;
   logic signed [55:0] turn_ff, turn_in;
   logic [30:0]        klo_ff, klo_in;
   logic [31:0]        dth_ff, dth_in;
   logic signed [49:0] part_ff, part_in;
   logic signed [35:0] dx_ff, dx_in, dy_ff, dy_in;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff, prod_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   ddo_rsp_type rsp_data_ff, rsp_data_in;

   logic        accept, rsp_free, rsp_load, rot_start;
   ddo_rot_type rot;

   logic signed [65:0] rnd8, rnd16, rnd17, pos_sum, pos_shr;
   logic [62:0]        klo_sum;
   logic [31:0]        dth_sum, mid, hd_rnd;
   logic signed [32:0] ds_sum, ds_diff;
   logic signed [16:0] vdiff, lin_sum;

   ddo_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (rot_start),
      .angle (mid),
      .rot   (rot)
   );

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_idx = ddo_csr_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         CSR_RAD_PER_TICK:   prdata = {8'h00, rpt_ff};
         CSR_WHEEL_RADIUS:   prdata = {16'h0000, rad_ff};
         CSR_INV_WHEEL_BASE: prdata = {8'h00, ibase_ff};
         default:            prdata = '0;
      endcase
   end

   always_comb begin
      rpt_in   = rpt_ff;
      rad_in   = rad_ff;
      ibase_in = ibase_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_RAD_PER_TICK:   rpt_in   = pwdata[23:0];
            CSR_WHEEL_RADIUS:   rad_in   = pwdata[15:0];
            CSR_INV_WHEEL_BASE: ibase_in = pwdata[23:0];
            default:            rpt_in   = rpt_ff;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DL;
         ST_DL:       state_in = ST_DR;
         ST_DR:       state_in = ST_RATE;
         ST_RATE:     state_in = ST_DS;
         ST_DS:       state_in = ST_ARC;
         ST_ARC:      state_in = ST_ARC_WB;
         ST_ARC_WB:   state_in = ST_TURN;
         ST_TURN:     state_in = ST_TURN_WB;
         ST_TURN_WB:  state_in = ST_KLO;
         ST_KLO:      state_in = ST_KHI;
         ST_KHI:      state_in = ST_KHI_WB;
         ST_KHI_WB:   state_in = ST_ROT_INIT;
         ST_ROT_INIT: state_in = ST_ROT;
         ST_ROT:      if (rot.done) state_in = ST_XLO;
         ST_XLO:      state_in = ST_XHI;
         ST_XHI:      state_in = ST_YLO;
         ST_YLO:      state_in = ST_YHI;
         ST_YHI:      state_in = ST_YHI_WB;
         ST_YHI_WB:   state_in = ST_ACC;
         ST_ACC:      state_in = ST_OUT;
         ST_OUT:      if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, rotator start, multiplier operands
   always_comb begin
      req_ready = 1'b0;
      rot_start = 1'b0;
      rsp_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE:     req_ready = 1'b1;
         ST_DL: begin
            mul_a = 33'(tl_ff);
            mul_b = {9'b0, rpt_ff};
         end
         ST_DR: begin
            mul_a = 33'(tr_ff);
            mul_b = {9'b0, rpt_ff};
         end
         ST_RATE: begin
            mul_a = 33'(vdiff);
            mul_b = {9'b0, ibase_ff};
         end
         ST_DS: begin
            mul_a = ds_sum;
            mul_b = {17'b0, rad_ff};
         end
         ST_ARC: begin
            mul_a = ds_diff;
            mul_b = {17'b0, rad_ff};
         end
         ST_TURN: begin
            mul_a = 33'(arc_ff);
            mul_b = {9'b0, ibase_ff};
         end
         ST_KLO: begin
            mul_a = {1'b0, turn_ff[31:0]};
            mul_b = {3'b0, INV_TWO_PI_Q32};
         end
         ST_KHI: begin
            mul_a = {{9{turn_ff[55]}}, turn_ff[55:32]};
            mul_b = {3'b0, INV_TWO_PI_Q32};
         end
         ST_ROT_INIT: rot_start = 1'b1;
         ST_XLO: begin
            mul_a = {17'b0, ds_ff[15:0]};
            mul_b = 33'(rot.cosine);
         end
         ST_XHI: begin
            mul_a = {{16{ds_ff[32]}}, ds_ff[32:16]};
            mul_b = 33'(rot.cosine);
         end
         ST_YLO: begin
            mul_a = {17'b0, ds_ff[15:0]};
            mul_b = 33'(rot.sine);
         end
         ST_YHI: begin
            mul_a = {{16{ds_ff[32]}}, ds_ff[32:16]};
            mul_b = 33'(rot.sine);
         end
         ST_OUT:      rsp_load = rsp_free;
         default:     req_ready = 1'b0;
      endcase
   end

   assign accept  = req_valid && req_ready;
   assign prod_in = mul_a * mul_b;

   // ---------------- datapath ----------------
   assign rnd8    = (prod_ff + 66'sd128) >>> 8;
   assign rnd16   = (prod_ff + 66'sd32768) >>> 16;
   assign rnd17   = (prod_ff + 66'sd65536) >>> 17;
   assign klo_sum = {1'b0, prod_ff[61:0]} + 63'd2147483648;
   assign dth_sum = prod_ff[31:0] + {1'b0, klo_ff};
   // low partial product already carries the rounding offset
   assign pos_sum = 66'(part_ff) + (prod_ff <<< 16);
   assign pos_shr = pos_sum >>> 30;
   assign ds_sum  = 33'(dl_ff) + 33'(dr_ff);
   assign ds_diff = 33'(dr_ff) - 33'(dl_ff);
   assign vdiff   = 17'(vr_ff) - 17'(vl_ff);
   assign lin_sum = 17'(req_data.left_speed) + 17'(req_data.right_speed) + 17'sd1;
   // mid heading: current heading plus the floor half of this sample's turn
   assign mid     = {hd_ff, 16'h0000} + {dth_ff[31], dth_ff[31:1]};
   assign hd_rnd  = dth_ff + 32'h0000_8000;

   always_comb begin
      last_l_in = last_l_ff;
      last_r_in = last_r_ff;
      acc_l_in  = acc_l_ff;
      acc_r_in  = acc_r_ff;
      acc_x_in  = acc_x_ff;
      acc_y_in  = acc_y_ff;
      hd_in     = hd_ff;
      tl_in     = tl_ff;
      tr_in     = tr_ff;
      vl_in     = vl_ff;
      vr_in     = vr_ff;
      lin_in    = lin_ff;
      rate_in   = rate_ff;
      dl_in     = dl_ff;
      dr_in     = dr_ff;
      ds_in     = ds_ff;
      arc_in    = arc_ff;
      turn_in   = turn_ff;
      klo_in    = klo_ff;
      dth_in    = dth_ff;
      part_in   = part_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tl_in     = req_data.left_count - last_l_ff;
               tr_in     = last_r_ff - req_data.right_count;
               last_l_in = req_data.left_count;
               last_r_in = req_data.right_count;
               vl_in     = req_data.left_speed;
               vr_in     = req_data.right_speed;
               lin_in    = lin_sum[16:1];
            end
         end
         ST_DR:      dl_in = sat32(rnd8);
         ST_RATE: begin
            dr_in    = sat32(rnd8);
            acc_l_in = sat32(66'(acc_l_ff) + 66'(dl_ff));
         end
         ST_DS: begin
            rate_in  = sat16(rnd16);
            acc_r_in = sat32(66'(acc_r_ff) + 66'(dr_ff));
         end
         ST_ARC:     ds_in   = rnd17[32:0];
         ST_ARC_WB:  arc_in  = sat32(rnd16);
         ST_TURN_WB: turn_in = prod_ff[55:0];
         ST_KHI:     klo_in  = klo_sum[62:32];
         ST_KHI_WB:  dth_in  = dth_sum;
         ST_ROT_INIT: hd_in  = hd_ff + hd_rnd[31:16];
         ST_XHI:     part_in = $signed(prod_ff[49:0]) + 50'sd536870912;
         ST_YLO:     dx_in   = pos_shr[35:0];
         ST_YHI: begin
            part_in  = $signed(prod_ff[49:0]) + 50'sd536870912;
            acc_x_in = sat32(66'(acc_x_ff) + 66'(dx_ff));
         end
         ST_YHI_WB:  dy_in    = pos_shr[35:0];
         ST_ACC:     acc_y_in = sat32(66'(acc_y_ff) + 66'(dy_ff));
         default:    dth_in   = dth_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.pose_x            = acc_x_ff;
         rsp_data_in.pose_y            = acc_y_ff;
         rsp_data_in.heading_angle     = hd_ff;
         rsp_data_in.linear_speed      = lin_ff;
         rsp_data_in.turn_rate         = rate_ff;
         rsp_data_in.left_wheel_angle  = acc_l_ff;
         rsp_data_in.right_wheel_angle = acc_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rpt_ff       <= RAD_PER_TICK_RST;
         rad_ff       <= WHEEL_RADIUS_RST;
         ibase_ff     <= INV_WHEEL_BASE_RST;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         acc_l_ff     <= '0;
         acc_r_ff     <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         hd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rpt_ff       <= rpt_in;
         rad_ff       <= rad_in;
         ibase_ff     <= ibase_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
         acc_l_ff     <= acc_l_in;
         acc_r_ff     <= acc_r_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         hd_ff        <= hd_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      tl_ff       <= tl_in;
      tr_ff       <= tr_in;
      vl_ff       <= vl_in;
      vr_ff       <= vr_in;
      lin_ff      <= lin_in;
      rate_ff     <= rate_in;
      dl_ff       <= dl_in;
      dr_ff       <= dr_in;
      ds_ff       <= ds_in;
      arc_ff      <= arc_in;
      turn_ff     <= turn_in;
      klo_ff      <= klo_in;
      dth_ff      <= dth_in;
      part_ff     <= part_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_rot_done_in_rot: assert property (@(posedge clock) disable iff (reset)
      rot.done |-> state_ff == ST_ROT)
      else $error("rotator finished outside the rotation step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DL)
      else $error("accepted transfer did not start the sequence");

   a_heading_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_ROT_INIT |=> $stable(hd_ff))
      else $error("heading changed outside its update step");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not loaded into a free output register");

endmodule
